// File: design/tqat_pkg.sv
// ----------------------------------------------------------------------------
// tqat_pkg
// Shared types and constants for the task quantum accounting table.
// ----------------------------------------------------------------------------
package tqat_pkg;

  // Default number of task slots
  localparam int MAX_TASKS_DEF = 16;

  // Field widths
  localparam int ID_W     = 16;
  localparam int TICK_W   = 32;
  localparam int ACTION_W = 3;

  // Operation codes carried on the request side
  typedef enum logic [ACTION_W-1:0] {
    ACT_REGISTER    = 3'd0,
    ACT_SET_QUANTUM = 3'd1,
    ACT_READ        = 3'd2,
    ACT_RESET       = 3'd3,
    ACT_TICK        = 3'd4
  } action_t;

  // Request sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_LOOK,
    ST_EXEC
  } state_t;

  // Summary of one tag search
  typedef struct packed {
    logic hit;
    logic free_any;
  } match_t;

  // One slot of the counter memory
  typedef struct packed {
    logic [TICK_W-1:0] quantum;
    logic [TICK_W-1:0] elapsed;
  } slot_entry_t;

endpackage

// File: design/task_quantum_accounting_table.sv
// ----------------------------------------------------------------------------
// task_quantum_accounting_table
// Per-task run-tick counters with quantum expiry flagging.
// ----------------------------------------------------------------------------
// Requests are taken one at a time. A request accepted on the input stream
// passes through tag compare, slot encode with counter memory read, and
// update and write back before its result is loaded into the output
// register; the load waits while the output side stalls. The next request
// is accepted in the cycle after the result is loaded, so a new request is
// not taken until the last one is through. This spacing is set by the
// read-modify-write of the counter memory behind the registered tag search.
// Tags clear in the reset cycle itself; the counter memory needs no clearing pass since a slot
// is zeroed whenever a task is registered into it.
module task_quantum_accounting_table #(
  parameter int MAX_TASKS = tqat_pkg::MAX_TASKS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: scheduler_notify_enable
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // [15:0] task_id, [47:16] quantum
  input  logic [2:0]  s_axis_tuser,  // [2:0] action
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // [0] ok, [32:1] runtime, [33] expired,
                                     // [34] notify_scheduler, [39:35] zero
);

  localparam int SLOT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int ID_W   = tqat_pkg::ID_W;
  localparam int TICK_W = tqat_pkg::TICK_W;
  localparam int ENT_W  = $bits(tqat_pkg::slot_entry_t);

  tqat_pkg::state_t state, state_next;

  // Latched request
  logic [tqat_pkg::ACTION_W-1:0] req_action;
  logic [ID_W-1:0]               req_id;
  logic [TICK_W-1:0]             req_quantum;

  logic notify_en;

  // Tag search
  tqat_pkg::match_t  match;
  logic [SLOT_W-1:0] hit_idx;
  logic [SLOT_W-1:0] free_idx;
  logic              cmp_en;
  logic              tag_we;

  // Counter memory
  logic [ENT_W-1:0]       slot_mem [MAX_TASKS];
  logic [ENT_W-1:0]       rd_data;
  tqat_pkg::slot_entry_t  rd_entry;
  tqat_pkg::slot_entry_t  wr_entry;
  logic                   mem_re;
  logic                   mem_we;
  logic [SLOT_W-1:0]      mem_waddr;

  // Result
  logic              out_free;
  logic              exec_fire;
  logic              res_ok;
  logic [TICK_W-1:0] res_runtime;
  logic              res_expired;
  logic [TICK_W-1:0] run_inc;

  // Hold notify enable
  always_ff @(posedge clk) begin
    if (rst) begin
      notify_en <= 1'b0;
    end else if (cfg_wr_en) begin
      notify_en <= cfg_wr_data;
    end
  end

  // Capture request on accept
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req_action  <= s_axis_tuser;
      req_id      <= s_axis_tdata[ID_W-1:0];
      req_quantum <= s_axis_tdata[ID_W +: TICK_W];
    end
  end

  tqat_tag_cam #(
    .MAX_TASKS (MAX_TASKS),
    .SLOT_W    (SLOT_W)
  ) u_tag_cam (
    .clk       (clk),
    .rst       (rst),
    .cmp_en    (cmp_en),
    .cmp_id    (req_id),
    .match     (match),
    .hit_idx   (hit_idx),
    .free_idx  (free_idx),
    .tag_we    (tag_we),
    .tag_waddr (free_idx),
    .tag_wdata (req_id)
  );

  // Counter memory: one write port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= wr_entry;
    end
    if (mem_re) begin
      rd_data <= slot_mem[hit_idx];
    end
  end

  // Advance sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tqat_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign exec_fire = (state == tqat_pkg::ST_EXEC) && out_free;
  assign rd_entry  = tqat_pkg::slot_entry_t'(rd_data);
  assign run_inc   = rd_entry.elapsed + TICK_W'(1);

  // Next state and per-state controls
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    cmp_en        = 1'b0;
    mem_re        = 1'b0;
    case (state)
      tqat_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_next = tqat_pkg::ST_MATCH;
        end
      end
      tqat_pkg::ST_MATCH: begin
        cmp_en     = 1'b1;
        state_next = tqat_pkg::ST_LOOK;
      end
      tqat_pkg::ST_LOOK: begin
        mem_re     = 1'b1;
        state_next = tqat_pkg::ST_EXEC;
      end
      tqat_pkg::ST_EXEC: begin
        if (out_free) begin
          state_next = tqat_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tqat_pkg::ST_IDLE;
      end
    endcase
  end

  // Update the slot and form the result
  always_comb begin
    tag_we      = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = hit_idx;
    wr_entry    = rd_entry;
    res_ok      = 1'b0;
    res_runtime = '0;
    res_expired = 1'b0;
    case (tqat_pkg::action_t'(req_action))
      tqat_pkg::ACT_REGISTER: begin
        if (req_id != '0 && !match.hit && match.free_any) begin
          tag_we           = exec_fire;
          mem_we           = exec_fire;
          mem_waddr        = free_idx;
          wr_entry.quantum = '0;
          wr_entry.elapsed = '0;
          res_ok           = 1'b1;
        end
      end
      tqat_pkg::ACT_SET_QUANTUM: begin
        if (req_quantum != '0 && match.hit) begin
          mem_we           = exec_fire;
          wr_entry.quantum = req_quantum;
          res_ok           = 1'b1;
        end
      end
      tqat_pkg::ACT_READ: begin
        if (match.hit) begin
          res_runtime = rd_entry.elapsed;
          res_ok      = 1'b1;
        end
      end
      tqat_pkg::ACT_RESET: begin
        if (match.hit) begin
          mem_we           = exec_fire;
          wr_entry.elapsed = '0;
          res_ok           = 1'b1;
        end
      end
      tqat_pkg::ACT_TICK: begin
        if (match.hit) begin
          mem_we           = exec_fire;
          wr_entry.elapsed = run_inc;
          res_ok           = 1'b1;
          res_expired      = (rd_entry.quantum != '0) && (run_inc >= rd_entry.quantum);
        end
      end
      default: begin
        res_ok = 1'b0;
      end
    endcase
  end

  // Output register: load on update, drop on take
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (exec_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      m_axis_tdata <= {5'b0, res_expired & notify_en, res_expired, res_runtime, res_ok};
    end
  end

endmodule

// File: design/tqat_tag_cam.sv
// ----------------------------------------------------------------------------
// tqat_tag_cam
// Task identifier store with a registered parallel compare and priority
// encoders for the matching slot and the lowest empty slot.
// ----------------------------------------------------------------------------
module tqat_tag_cam #(
  parameter int MAX_TASKS = tqat_pkg::MAX_TASKS_DEF,
  parameter int SLOT_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  // search
  input  logic                      cmp_en,
  input  logic [tqat_pkg::ID_W-1:0] cmp_id,
  output tqat_pkg::match_t          match,
  output logic [SLOT_W-1:0]         hit_idx,
  output logic [SLOT_W-1:0]         free_idx,
  // tag write
  input  logic                      tag_we,
  input  logic [SLOT_W-1:0]         tag_waddr,
  input  logic [tqat_pkg::ID_W-1:0] tag_wdata
);

  logic [tqat_pkg::ID_W-1:0] slot_task [MAX_TASKS];
  logic [MAX_TASKS-1:0]      hit_vec;
  logic [MAX_TASKS-1:0]      free_vec;

  // Hold tags; clear every slot on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        slot_task[i] <= '0;
      end
    end else if (tag_we) begin
      slot_task[tag_waddr] <= tag_wdata;
    end
  end

  // Compare every slot at once and register the result vectors
  always_ff @(posedge clk) begin
    if (cmp_en) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        hit_vec[i]  <= (slot_task[i] == cmp_id) && (cmp_id != '0);
        free_vec[i] <= (slot_task[i] == '0);
      end
    end
  end

  // Encode lowest set bit of each vector
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = MAX_TASKS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = SLOT_W'(i);
      end
      if (free_vec[i]) begin
        free_idx = SLOT_W'(i);
      end
    end
    match.hit      = |hit_vec;
    match.free_any = |free_vec;
  end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb - task quantum accounting table testbench
// Streams register, set-quantum, read, reset, tick and unknown-action requests
// through the table with random gaps and output stalls. A local copy of the
// slot table predicts each result, and every result is checked field by
// field, in order. The notify enable is changed between phases while idle.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOTS      = tqat_pkg::MAX_TASKS_DEF;
  localparam int ID_W        = tqat_pkg::ID_W;
  localparam int TICK_W      = tqat_pkg::TICK_W;
  localparam int ACTION_W    = tqat_pkg::ACTION_W;
  localparam int CYCLE_LIMIT = 200000;

  // Expected fields of one result
  typedef struct packed {
    logic              ok;
    logic [TICK_W-1:0] runtime;
    logic              expired;
    logic              notify;
  } outcome_t;

  // One pending request
  typedef struct packed {
    logic [ACTION_W-1:0] act;
    logic [ID_W-1:0]     id;
    logic [TICK_W-1:0]   quantum;
  } req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;  // [15:0] task_id, [47:16] quantum
  logic [2:0]  s_axis_tuser = '0;  // [2:0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;       // [0] ok, [32:1] runtime, [33] expired,
                                   // [34] notify_scheduler

  task_quantum_accounting_table u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow slot table and notify enable
  logic [ID_W-1:0]   tab_id      [NSLOTS];
  logic [TICK_W-1:0] tab_ticks   [NSLOTS];
  logic [TICK_W-1:0] tab_quantum [NSLOTS];
  logic              notify_en;

  req_t     req_backlog[$];
  outcome_t outcome_due[$];
  int       errors = 0;
  int       cycles = 0;
  logic [ID_W-1:0] focus_id = '0;

  // Apply one request to the shadow table and return its result
  function automatic outcome_t account(input logic [ACTION_W-1:0] act,
                                       input logic [ID_W-1:0] id,
                                       input logic [TICK_W-1:0] q);
    outcome_t r;
    int hit;
    int vacant;
    r = '0;
    hit = -1;
    vacant = -1;
    for (int i = 0; i < NSLOTS; i++) begin
      if (id != '0 && hit < 0 && tab_id[i] == id) hit = i;
      if (vacant < 0 && tab_id[i] == '0) vacant = i;
    end
    case (act)
      tqat_pkg::ACT_REGISTER: begin
        if (id != '0 && hit < 0 && vacant >= 0) begin
          tab_id[vacant] = id;
          tab_ticks[vacant] = '0;
          tab_quantum[vacant] = '0;
          r.ok = 1'b1;
        end
      end
      tqat_pkg::ACT_SET_QUANTUM: begin
        if (q != '0 && hit >= 0) begin
          tab_quantum[hit] = q;
          r.ok = 1'b1;
        end
      end
      tqat_pkg::ACT_READ: begin
        if (hit >= 0) begin
          r.runtime = tab_ticks[hit];
          r.ok = 1'b1;
        end
      end
      tqat_pkg::ACT_RESET: begin
        if (hit >= 0) begin
          tab_ticks[hit] = '0;
          r.ok = 1'b1;
        end
      end
      tqat_pkg::ACT_TICK: begin
        if (hit >= 0) begin
          tab_ticks[hit] = tab_ticks[hit] + 1'b1;
          r.ok = 1'b1;
          if (tab_quantum[hit] != '0 && tab_ticks[hit] >= tab_quantum[hit])
            r.expired = 1'b1;
        end
      end
      default: ;
    endcase
    r.notify = r.expired & notify_en;
    return r;
  endfunction

  // Draw a random wait, or none in a gap-free run; alternate gappy and gap-free runs
  function automatic int draw_wait(inout int run_left, inout bit dense);
    if (run_left == 0) begin
      run_left = $urandom_range(20, 60);
      dense = ~dense;
    end
    run_left--;
    return dense ? 0 : $urandom_range(0, 4);
  endfunction

  // Driver: present queued requests, hold while stalled, idle for the drawn gap between them
  int req_gap = 0;
  int drv_run = 0;
  bit drv_dense = 1'b1;
  req_t nxt_req;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        outcome_due.push_back(account(s_axis_tuser, s_axis_tdata[15:0],
                                      s_axis_tdata[47:16]));
        req_gap = draw_wait(drv_run, drv_dense);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (req_gap > 0) begin
          req_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (req_backlog.size() > 0) begin
          nxt_req = req_backlog.pop_front();
          s_axis_tdata <= {nxt_req.quantum, nxt_req.id};
          s_axis_tuser <= nxt_req.act;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result against the oldest prediction, stall at random
  int res_stall = 0;
  int mon_run = 0;
  bit mon_dense = 1'b0;
  int stall_nxt;
  outcome_t want;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      res_stall = 0;
    end else begin
      stall_nxt = res_stall;
      if (m_axis_tvalid && m_axis_tready) begin
        if (outcome_due.size() == 0) begin
          $error("result with no request outstanding: %h", m_axis_tdata);
          errors++;
        end else begin
          want = outcome_due.pop_front();
          if (m_axis_tdata[0] !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, m_axis_tdata[0]);
            errors++;
          end
          if (m_axis_tdata[32:1] !== want.runtime) begin
            $error("runtime: expected %0d, got %0d", want.runtime, m_axis_tdata[32:1]);
            errors++;
          end
          if (m_axis_tdata[33] !== want.expired) begin
            $error("expired: expected %0d, got %0d", want.expired, m_axis_tdata[33]);
            errors++;
          end
          if (m_axis_tdata[34] !== want.notify) begin
            $error("notify_scheduler: expected %0d, got %0d", want.notify,
                   m_axis_tdata[34]);
            errors++;
          end
        end
        stall_nxt = draw_wait(mon_run, mon_dense);
      end
      if (stall_nxt > 0) begin
        m_axis_tready <= 1'b0;
        res_stall = stall_nxt - 1;
      end else begin
        m_axis_tready <= 1'b1;
        res_stall = 0;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("task_quantum_accounting_table verification failed");
      $finish;
    end
  end

  task automatic queue_req(input logic [ACTION_W-1:0] act, input logic [ID_W-1:0] id,
                           input logic [TICK_W-1:0] q);
    req_t r;
    r.act = act;
    r.id = id;
    r.quantum = q;
    req_backlog.push_back(r);
  endtask

  // Wait until every request is taken and answered, then let the pipe drain
  task automatic drain();
    while (req_backlog.size() != 0 || s_axis_tvalid || outcome_due.size() != 0)
      @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_notify(input logic v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    notify_en = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Pick an id: mostly a registered task, sometimes unknown, small or zero
  function automatic logic [ID_W-1:0] pick_id();
    logic [ID_W-1:0] known[$];
    int roll;
    for (int i = 0; i < NSLOTS; i++)
      if (tab_id[i] != '0) known.push_back(tab_id[i]);
    roll = $urandom_range(0, 99);
    if (roll < 65 && known.size() > 0) return known[$urandom_range(0, known.size() - 1)];
    if (roll < 80) return ID_W'($urandom_range(1, 8));
    if (roll < 85) return '0;
    return ID_W'($urandom);
  endfunction

  function automatic logic [TICK_W-1:0] pick_quantum();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return $urandom_range(1, 12);
    if (roll < 60) return '0;
    return $urandom;
  endfunction

  // Random mix weighted toward ticks on a focus task
  task automatic queue_random(input int n);
    int roll;
    logic [ID_W-1:0] id;
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      id = pick_id();
      if (roll < 12) begin
        if ($urandom_range(0, 1)) id = ID_W'($urandom);
        queue_req(tqat_pkg::ACT_REGISTER, id, $urandom);
        focus_id = id;
      end else if (roll < 27) begin
        queue_req(tqat_pkg::ACT_SET_QUANTUM, id, pick_quantum());
        if (id != '0) focus_id = id;
      end else if (roll < 42) begin
        queue_req(tqat_pkg::ACT_READ, id, $urandom);
      end else if (roll < 52) begin
        queue_req(tqat_pkg::ACT_RESET, id, $urandom);
      end else if (roll < 93) begin
        if ($urandom_range(0, 9) < 6 && focus_id != '0) id = focus_id;
        queue_req(tqat_pkg::ACT_TICK, id, $urandom);
      end else begin
        queue_req(3'($urandom_range(5, 7)), id, $urandom);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < NSLOTS; i++) begin
      tab_id[i] = '0;
      tab_ticks[i] = '0;
      tab_quantum[i] = '0;
    end
    notify_en = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    write_notify(1'b1);

    // Directed: zero id, duplicates, quantum edges, repeated expiry, resets
    queue_req(tqat_pkg::ACT_REGISTER, '0, '0);
    queue_req(tqat_pkg::ACT_TICK, '0, '0);
    queue_req(tqat_pkg::ACT_READ, '0, '1);
    queue_req(tqat_pkg::ACT_REGISTER, 16'hFFFF, '0);
    queue_req(tqat_pkg::ACT_REGISTER, 16'hFFFF, '1);
    queue_req(tqat_pkg::ACT_REGISTER, 16'h0001, '0);
    queue_req(tqat_pkg::ACT_SET_QUANTUM, 16'h0001, '0);
    queue_req(tqat_pkg::ACT_SET_QUANTUM, 16'h0002, 32'd5);
    queue_req(tqat_pkg::ACT_SET_QUANTUM, 16'hFFFF, 32'hFFFF_FFFF);
    queue_req(tqat_pkg::ACT_SET_QUANTUM, 16'h0001, 32'd2);
    queue_req(tqat_pkg::ACT_TICK, 16'h0001, '0);
    queue_req(tqat_pkg::ACT_TICK, 16'h0001, '0);
    queue_req(tqat_pkg::ACT_TICK, 16'h0001, '1);
    queue_req(tqat_pkg::ACT_READ, 16'h0001, '0);
    queue_req(tqat_pkg::ACT_RESET, 16'h0001, '0);
    queue_req(tqat_pkg::ACT_READ, 16'h0001, '0);
    queue_req(tqat_pkg::ACT_TICK, 16'h0001, '0);
    queue_req(tqat_pkg::ACT_TICK, 16'hFFFF, '0);
    queue_req(tqat_pkg::ACT_READ, 16'hFFFF, 32'hFFFF_FFFF);
    queue_req(tqat_pkg::ACT_RESET, 16'h1234, '0);
    queue_req(tqat_pkg::ACT_TICK, 16'h1234, '0);
    queue_req(3'd5, 16'h0001, '1);
    queue_req(3'd6, 16'hFFFF, 32'hA5A5_5A5A);
    queue_req(3'd7, 16'h0001, '0);
    drain();

    // Random phases across both notify settings
    write_notify(1'b0);
    queue_random(250);
    drain();
    write_notify(1'b1);
    queue_random(250);
    drain();
    write_notify(1'b0);
    queue_random(250);
    drain();

    if (errors == 0) begin
      $display("task_quantum_accounting_table verification clean");
    end else begin
      $display("task_quantum_accounting_table verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
design/tqat_pkg.sv
design/tqat_tag_cam.sv
design/task_quantum_accounting_table.sv
tb/tb.sv
